/* rtl/hsv2rgb_pkg.sv */
`timescale 1ns / 1ps

package hsv2rgb_pkg;

    // Channel size and the fixed-point constants that follow from it.
    localparam int CHANNEL_BITS = 8;
    localparam int HUE_W        = 9;

    localparam longint unsigned MAXV       = (64'd1 << CHANNEL_BITS) - 64'd1;
    localparam longint unsigned SECTOR_DEG = 60;
    localparam longint unsigned FULL_TURN  = 360;
    localparam int              FRAC_W     = $clog2(SECTOR_DEG + 1);

    // Denominator of q and t, and the rounding offsets (half the divisor).
    localparam longint unsigned DEN_Q  = SECTOR_DEG * MAXV;
    localparam int              DEN_W  = $clog2(DEN_Q + 1);
    localparam longint unsigned HALF_P = MAXV / 2;
    localparam longint unsigned HALF_Q = DEN_Q / 2;

    // Numerator widths, rounding offset included.
    localparam int NUM_P_W = $clog2(MAXV * MAXV + HALF_P + 1);
    localparam int NUM_Q_W = $clog2(MAXV * DEN_Q + HALF_Q + 1);

    // Reciprocal constants. With a shift of the numerator width plus the
    // divisor's bit length, the rounded-up reciprocal gives an exact floor.
    localparam int              SHIFT_P   = NUM_P_W + $clog2(MAXV);
    localparam int              SHIFT_Q   = NUM_Q_W + $clog2(DEN_Q);
    localparam longint unsigned RECIP_P   = ((64'd1 << SHIFT_P) + MAXV - 64'd1) / MAXV;
    localparam longint unsigned RECIP_Q   = ((64'd1 << SHIFT_Q) + DEN_Q - 64'd1) / DEN_Q;
    localparam int              RECIP_P_W = $clog2(RECIP_P + 1);
    localparam int              RECIP_Q_W = $clog2(RECIP_Q + 1);

    // Hue sectors of sixty degrees each.
    typedef enum logic [2:0] {
        SECT_RY = 3'd0,
        SECT_YG = 3'd1,
        SECT_GC = 3'd2,
        SECT_CB = 3'd3,
        SECT_BM = 3'd4,
        SECT_MR = 3'd5
    } sector_t;

    typedef struct packed {
        logic [HUE_W-1:0]        hue;
        logic [CHANNEL_BITS-1:0] saturation;
        logic [CHANNEL_BITS-1:0] brightness;
    } hsv_word_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } rgb_word_t;

    typedef struct packed {
        sector_t                 sector;
        logic [FRAC_W-1:0]       frac;
        logic [CHANNEL_BITS-1:0] sat;
        logic [CHANNEL_BITS-1:0] val;
    } sect_word_t;

    typedef struct packed {
        sector_t                 sector;
        logic [CHANNEL_BITS-1:0] val;
        logic [NUM_P_W-1:0]      num_p;
        logic [NUM_Q_W-1:0]      num_q;
        logic [NUM_Q_W-1:0]      num_t;
    } num_word_t;

    typedef struct packed {
        sector_t                 sector;
        logic [CHANNEL_BITS-1:0] val;
        logic [CHANNEL_BITS-1:0] lev_p;
        logic [CHANNEL_BITS-1:0] lev_q;
        logic [CHANNEL_BITS-1:0] lev_t;
    } lev_word_t;

endpackage

/* rtl/hsv2rgb_sector.sv */
`timescale 1ns / 1ps

module hsv2rgb_sector
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   up_valid,
    output logic                   up_ready,
    input  hsv2rgb_pkg::hsv_word_t up_word,
    output logic                   dn_valid,
    input  logic                   dn_ready,
    output hsv2rgb_pkg::sect_word_t dn_word
);
    import hsv2rgb_pkg::*;

    logic [HUE_W-1:0] hue_wrap;
    logic [HUE_W-1:0] base;
    logic [HUE_W-1:0] offset;
    sector_t          sector;
    sect_word_t       word_next;
    sect_word_t       word_reg;
    logic             valid_reg;

    // A hue of a full turn or more counts as zero degrees.
    assign hue_wrap = (up_word.hue >= HUE_W'(FULL_TURN)) ? '0 : up_word.hue;

    always_comb
    begin
        if (hue_wrap >= HUE_W'(5 * SECTOR_DEG))
        begin
            sector = SECT_MR;
            base   = HUE_W'(5 * SECTOR_DEG);
        end
        else if (hue_wrap >= HUE_W'(4 * SECTOR_DEG))
        begin
            sector = SECT_BM;
            base   = HUE_W'(4 * SECTOR_DEG);
        end
        else if (hue_wrap >= HUE_W'(3 * SECTOR_DEG))
        begin
            sector = SECT_CB;
            base   = HUE_W'(3 * SECTOR_DEG);
        end
        else if (hue_wrap >= HUE_W'(2 * SECTOR_DEG))
        begin
            sector = SECT_GC;
            base   = HUE_W'(2 * SECTOR_DEG);
        end
        else if (hue_wrap >= HUE_W'(SECTOR_DEG))
        begin
            sector = SECT_YG;
            base   = HUE_W'(SECTOR_DEG);
        end
        else
        begin
            sector = SECT_RY;
            base   = '0;
        end
    end

    assign offset = hue_wrap - base;

    always_comb
    begin
        word_next.sector = sector;
        word_next.frac   = offset[FRAC_W-1:0];
        word_next.sat    = up_word.saturation;
        word_next.val    = up_word.brightness;
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            word_reg <= word_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

    a_frac_in_sector: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (word_reg.frac < FRAC_W'(SECTOR_DEG)))
        else $error("sector offset out of range");

endmodule

/* rtl/hsv2rgb_numer.sv */
`timescale 1ns / 1ps

module hsv2rgb_numer
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    up_valid,
    output logic                    up_ready,
    input  hsv2rgb_pkg::sect_word_t up_word,
    output logic                    dn_valid,
    input  logic                    dn_ready,
    output hsv2rgb_pkg::num_word_t  dn_word
);
    import hsv2rgb_pkg::*;

    typedef struct packed {
        sector_t                 sector;
        logic [CHANNEL_BITS-1:0] val;
        logic [CHANNEL_BITS-1:0] diff_p;
        logic [DEN_W-1:0]        diff_q;
        logic [DEN_W-1:0]        diff_t;
    } diff_word_t;

    logic [DEN_W-1:0] sat_frac;
    logic [DEN_W-1:0] sat_rest;
    diff_word_t       diff_next;
    diff_word_t       diff_reg;
    logic             diff_valid_reg;
    logic             diff_ready;
    num_word_t        num_next;
    num_word_t        num_reg;
    logic             num_valid_reg;

    // First stage: the saturation terms that scale v for p, q and t.
    assign sat_frac = DEN_W'(up_word.sat) * DEN_W'(up_word.frac);
    assign sat_rest = DEN_W'(up_word.sat) * (DEN_W'(SECTOR_DEG) - DEN_W'(up_word.frac));

    always_comb
    begin
        diff_next.sector = up_word.sector;
        diff_next.val    = up_word.val;
        diff_next.diff_p = CHANNEL_BITS'(MAXV) - up_word.sat;
        diff_next.diff_q = DEN_W'(DEN_Q) - sat_frac;
        diff_next.diff_t = DEN_W'(DEN_Q) - sat_rest;
    end

    // Second stage: numerators with half the divisor added for rounding.
    always_comb
    begin
        num_next.sector = diff_reg.sector;
        num_next.val    = diff_reg.val;
        num_next.num_p  = NUM_P_W'(diff_reg.val) * NUM_P_W'(diff_reg.diff_p)
                          + NUM_P_W'(HALF_P);
        num_next.num_q  = NUM_Q_W'(diff_reg.val) * NUM_Q_W'(diff_reg.diff_q)
                          + NUM_Q_W'(HALF_Q);
        num_next.num_t  = NUM_Q_W'(diff_reg.val) * NUM_Q_W'(diff_reg.diff_t)
                          + NUM_Q_W'(HALF_Q);
    end

    assign up_ready   = !diff_valid_reg || diff_ready;
    assign diff_ready = !num_valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_valid_reg <= 1'b0;
            num_valid_reg  <= 1'b0;
        end
        else
        begin
            if (up_ready)
            begin
                diff_valid_reg <= up_valid;
            end
            if (diff_ready)
            begin
                num_valid_reg <= diff_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            diff_reg <= diff_next;
        end
        if (diff_valid_reg && diff_ready)
        begin
            num_reg <= num_next;
        end
    end

    assign dn_valid = num_valid_reg;
    assign dn_word  = num_reg;

endmodule

/* rtl/hsv2rgb_recip.sv */
`timescale 1ns / 1ps

module hsv2rgb_recip
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   up_valid,
    output logic                   up_ready,
    input  hsv2rgb_pkg::num_word_t up_word,
    output logic                   dn_valid,
    input  logic                   dn_ready,
    output hsv2rgb_pkg::lev_word_t dn_word
);
    import hsv2rgb_pkg::*;

    localparam int PROD_P_W = NUM_P_W + RECIP_P_W;
    localparam int PROD_Q_W = NUM_Q_W + RECIP_Q_W;

    logic [PROD_P_W-1:0] prod_p;
    logic [PROD_Q_W-1:0] prod_q;
    logic [PROD_Q_W-1:0] prod_t;
    lev_word_t           word_next;
    lev_word_t           word_reg;
    logic                valid_reg;

    // Division by a constant as a multiplication by its reciprocal; the shift
    // is wide enough that the quotient is the exact floor for every numerator.
    assign prod_p = PROD_P_W'(up_word.num_p) * PROD_P_W'(RECIP_P);
    assign prod_q = PROD_Q_W'(up_word.num_q) * PROD_Q_W'(RECIP_Q);
    assign prod_t = PROD_Q_W'(up_word.num_t) * PROD_Q_W'(RECIP_Q);

    always_comb
    begin
        word_next.sector = up_word.sector;
        word_next.val    = up_word.val;
        word_next.lev_p  = prod_p[SHIFT_P +: CHANNEL_BITS];
        word_next.lev_q  = prod_q[SHIFT_Q +: CHANNEL_BITS];
        word_next.lev_t  = prod_t[SHIFT_Q +: CHANNEL_BITS];
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            word_reg <= word_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

    // p is the smallest level and v the largest; q and t lie between them.
    a_level_order: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (word_reg.lev_p <= word_reg.lev_q) && (word_reg.lev_p <= word_reg.lev_t)
                      && (word_reg.lev_q <= word_reg.val) && (word_reg.lev_t <= word_reg.val))
        else $error("intermediate levels out of order");

    a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (up_valid && up_ready) |=> valid_reg)
        else $error("accepted word lost in reciprocal stage");

endmodule

/* rtl/hsv_to_rgb_pixel_top.sv */
`timescale 1ns / 1ps
// HSV to RGB pixel converter, five register stages deep.
// Each word passes through the sector, saturation-term, numerator, reciprocal and output
// registers in that order; an output-side stall can hold it in any of them.
// One word per clock unless stalled; every stage is a single register with its own valid bit.
// Reset (rst_n, asynchronous, active low) clears only the valid bits, not the data.

module hsv_to_rgb_pixel_top
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pix_hsv_valid,
    output logic                   pix_hsv_ready,
    input  hsv2rgb_pkg::hsv_word_t pix_hsv,
    output logic                   pix_rgb_valid,
    input  logic                   pix_rgb_ready,
    output hsv2rgb_pkg::rgb_word_t pix_rgb
);
    import hsv2rgb_pkg::*;

    // Stage boundaries. Each stage is ready when it is empty or when the stage
    // after it takes its word, so bubbles close up and a stall holds every word
    // in place without loss or repetition.
    logic       sect_valid;
    logic       sect_ready;
    sect_word_t sect_word;
    logic       num_valid;
    logic       num_ready;
    num_word_t  num_word;
    logic       lev_valid;
    logic       lev_ready;
    lev_word_t  lev_word;

    rgb_word_t  rgb_next;
    rgb_word_t  rgb_reg;
    logic       rgb_valid_reg;

    // Stage one: wrap the hue and split it into a sector and an offset.
    hsv2rgb_sector u_sector
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (pix_hsv_valid),
        .up_ready (pix_hsv_ready),
        .up_word  (pix_hsv),
        .dn_valid (sect_valid),
        .dn_ready (sect_ready),
        .dn_word  (sect_word)
    );

    // Stages two and three: saturation terms, then the rounded numerators.
    hsv2rgb_numer u_numer
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (sect_valid),
        .up_ready (sect_ready),
        .up_word  (sect_word),
        .dn_valid (num_valid),
        .dn_ready (num_ready),
        .dn_word  (num_word)
    );

    // Stage four: divide by the constant denominators through reciprocals.
    hsv2rgb_recip u_recip
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (num_valid),
        .up_ready (num_ready),
        .up_word  (num_word),
        .dn_valid (lev_valid),
        .dn_ready (lev_ready),
        .dn_word  (lev_word)
    );

    // Stage five: the sector chooses which level drives each channel. Zero
    // saturation needs no special path, as p, q and t then all equal v and
    // every sector gives gray.
    always_comb
    begin
        case (lev_word.sector)
            SECT_RY:
            begin
                rgb_next.red   = lev_word.val;
                rgb_next.green = lev_word.lev_t;
                rgb_next.blue  = lev_word.lev_p;
            end
            SECT_YG:
            begin
                rgb_next.red   = lev_word.lev_q;
                rgb_next.green = lev_word.val;
                rgb_next.blue  = lev_word.lev_p;
            end
            SECT_GC:
            begin
                rgb_next.red   = lev_word.lev_p;
                rgb_next.green = lev_word.val;
                rgb_next.blue  = lev_word.lev_t;
            end
            SECT_CB:
            begin
                rgb_next.red   = lev_word.lev_p;
                rgb_next.green = lev_word.lev_q;
                rgb_next.blue  = lev_word.val;
            end
            SECT_BM:
            begin
                rgb_next.red   = lev_word.lev_t;
                rgb_next.green = lev_word.lev_p;
                rgb_next.blue  = lev_word.val;
            end
            default:
            begin
                rgb_next.red   = lev_word.val;
                rgb_next.green = lev_word.lev_p;
                rgb_next.blue  = lev_word.lev_q;
            end
        endcase
    end

    // The output register separates the two sides: a finished word may wait
    // here while the stages behind it keep filling.
    assign lev_ready = !rgb_valid_reg || pix_rgb_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rgb_valid_reg <= 1'b0;
        end
        else if (lev_ready)
        begin
            rgb_valid_reg <= lev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lev_valid && lev_ready)
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign pix_rgb_valid = rgb_valid_reg;
    assign pix_rgb       = rgb_reg;

    a_out_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (lev_valid && lev_ready) |=> rgb_valid_reg)
        else $error("selected word not registered at the output");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rgb_valid_reg && !pix_rgb_ready) |=> (rgb_valid_reg && $stable(rgb_reg)))
        else $error("output word changed while stalled");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

// Testbench for hsv_to_rgb_pixel_top.
//
// Each HSV word is pushed through the valid/ready input channel. At the edge
// that accepts it, the RGB word it should produce is worked out here and
// queued. Every RGB word that leaves the block is compared field by field
// with the oldest queued word. The block keeps no state between pixels, so
// the expected word depends on the one input word alone.
//
// The stimulus opens with a directed set: sector edges, out-of-range hues,
// grey pixels and the extremes of saturation and brightness. Random pixels
// follow in four handshake phases:
//   - no idling on either side;
//   - a sender that idles most of the time;
//   - a receiver that stalls most of the time;
//   - both sides idling now and then.
// Between phases the sender holds off until every queued word has come out.

module tb;

    import hsv2rgb_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no word accepted on either side
    localparam int TAIL_CYCLES    = 16;    // idle cycles spent watching for stray words
    localparam int REPORT_LIMIT   = 10;

    logic      clk;
    logic      rst_n         = 1'b0;
    logic      pix_hsv_valid = 1'b0;
    hsv_word_t pix_hsv       = '0;
    logic      pix_hsv_ready;
    logic      pix_rgb_valid;
    logic      pix_rgb_ready = 1'b0;
    rgb_word_t pix_rgb;

    // Handshake pressure, in percent, changed between phases.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // RGB words still to come out of the block, oldest first.
    rgb_word_t   rgb_pending[$];
    rgb_word_t   rgb_want;

    int unsigned words_sent     = 0;
    int unsigned words_checked  = 0;
    int unsigned mismatch_count = 0;
    int unsigned stray_count    = 0;
    int unsigned quiet_cycles   = 0;

    hsv_to_rgb_pixel_top u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .pix_hsv_valid (pix_hsv_valid),
        .pix_hsv_ready (pix_hsv_ready),
        .pix_hsv       (pix_hsv),
        .pix_rgb_valid (pix_rgb_valid),
        .pix_rgb_ready (pix_rgb_ready),
        .pix_rgb       (pix_rgb)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Integer division rounded half up.
    function automatic longint unsigned div_half_up(longint unsigned num, longint unsigned den);
        return (2 * num + den) / (2 * den);
    endfunction

    // The RGB word that one HSV word should turn into.
    function automatic rgb_word_t rgb_from_hsv(hsv_word_t pix);
        longint unsigned hue;
        longint unsigned sat;
        longint unsigned val;
        longint unsigned frac;
        longint unsigned den;
        longint unsigned lev_p;
        longint unsigned lev_q;
        longint unsigned lev_t;
        sector_t         sect;
        rgb_word_t       rgb;
        hue = pix.hue;
        sat = pix.saturation;
        val = pix.brightness;
        // A hue of a full turn or more is taken as zero degrees.
        if (hue >= FULL_TURN)
            hue = 0;
        if (sat == 0)
        begin
            // Grey: all three channels carry the brightness.
            rgb.red   = CHANNEL_BITS'(val);
            rgb.green = CHANNEL_BITS'(val);
            rgb.blue  = CHANNEL_BITS'(val);
            return rgb;
        end
        sect  = sector_t'(3'(hue / SECTOR_DEG));
        frac  = hue % SECTOR_DEG;
        den   = SECTOR_DEG * MAXV;
        lev_p = div_half_up(val * (MAXV - sat), MAXV);
        lev_q = div_half_up(val * (den - sat * frac), den);
        lev_t = div_half_up(val * (den - sat * (SECTOR_DEG - frac)), den);
        case (sect)
            SECT_RY: rgb = '{CHANNEL_BITS'(val),   CHANNEL_BITS'(lev_t), CHANNEL_BITS'(lev_p)};
            SECT_YG: rgb = '{CHANNEL_BITS'(lev_q), CHANNEL_BITS'(val),   CHANNEL_BITS'(lev_p)};
            SECT_GC: rgb = '{CHANNEL_BITS'(lev_p), CHANNEL_BITS'(val),   CHANNEL_BITS'(lev_t)};
            SECT_CB: rgb = '{CHANNEL_BITS'(lev_p), CHANNEL_BITS'(lev_q), CHANNEL_BITS'(val)};
            SECT_BM: rgb = '{CHANNEL_BITS'(lev_t), CHANNEL_BITS'(lev_p), CHANNEL_BITS'(val)};
            default: rgb = '{CHANNEL_BITS'(val),   CHANNEL_BITS'(lev_p), CHANNEL_BITS'(lev_q)};
        endcase
        return rgb;
    endfunction

    // A random pixel. Hues of a full turn or more, zero and full saturation and the
    // brightness extremes each turn up about one time in ten.
    function automatic hsv_word_t random_hsv();
        hsv_word_t pix;
        pix.hue = ($urandom_range(9) == 0) ? HUE_W'($urandom_range(511, 360))
                                           : HUE_W'($urandom_range(359));
        case ($urandom_range(9))
            0:       pix.saturation = '0;
            1:       pix.saturation = '1;
            default: pix.saturation = CHANNEL_BITS'($urandom);
        endcase
        case ($urandom_range(9))
            0:       pix.brightness = '0;
            1:       pix.brightness = '1;
            default: pix.brightness = CHANNEL_BITS'($urandom);
        endcase
        return pix;
    endfunction

    // Sends one word. It is called at a falling edge and returns at one. Valid
    // is lowered only when the sender decides to idle, so back-to-back words
    // keep it high without a glitch.
    task automatic send_pixel(input hsv_word_t pix);
        if ($urandom_range(99) < send_idle_pct)
        begin
            pix_hsv_valid <= 1'b0;
            pix_hsv       <= random_hsv();
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        pix_hsv_valid <= 1'b1;
        pix_hsv       <= pix;
        do
            @(posedge clk);
        while (!pix_hsv_ready);
        rgb_pending.push_back(rgb_from_hsv(pix));
        words_sent++;
        @(negedge clk);
    endtask

    // Holds the sender off until every queued word has come out.
    task automatic drain_pixels();
        pix_hsv_valid <= 1'b0;
        while (rgb_pending.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_sector_edges();
        hsv_word_t pix;
        // The first and last degree of every sector, at full saturation and value.
        for (int sect = 0; sect < 6; sect++)
        begin
            pix = '{HUE_W'(sect * 60), 8'd255, 8'd255};
            send_pixel(pix);
            pix = '{HUE_W'(sect * 60 + 59), 8'd255, 8'd255};
            send_pixel(pix);
        end
        drain_pixels();
    endtask

    task automatic test_hue_wrap();
        // Hues of a full turn and beyond fold back to zero degrees.
        send_pixel('{9'd360, 8'd200, 8'd180});
        send_pixel('{9'd511, 8'd200, 8'd180});
        send_pixel('{9'd256, 8'd170, 8'd85});
        drain_pixels();
    endtask

    task automatic test_channel_extremes();
        send_pixel('{9'd200, 8'd0, 8'd137});    // grey
        send_pixel('{9'd0, 8'd0, 8'd255});      // white
        send_pixel('{9'd100, 8'd255, 8'd0});    // black at full saturation
        send_pixel('{9'd30, 8'd255, 8'd1});     // dimmest lit pixel
        send_pixel('{9'd250, 8'd1, 8'd255});    // faintest tint
        send_pixel('{9'd45, 8'd128, 8'd128});   // rounding near one half
        send_pixel('{9'd330, 8'd127, 8'd254});
        drain_pixels();
    endtask

    task automatic test_random_pixels(input int unsigned count, input int unsigned idle_pct,
                                      input int unsigned stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_pixel(random_hsv());
        drain_pixels();
    endtask

    // The receiver decides anew at every falling edge whether to take a word.
    always @(negedge clk)
        pix_rgb_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Compare each word that leaves the block with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && pix_rgb_valid && pix_rgb_ready)
        begin
            if (rgb_pending.size() == 0)
            begin
                stray_count++;
                if (mismatch_count + stray_count <= REPORT_LIMIT)
                    $display("%0t: word out with none expected: r=%0d g=%0d b=%0d",
                             $realtime, pix_rgb.red, pix_rgb.green, pix_rgb.blue);
            end
            else
            begin
                rgb_want = rgb_pending.pop_front();
                words_checked++;
                if (pix_rgb.red !== rgb_want.red || pix_rgb.green !== rgb_want.green
                    || pix_rgb.blue !== rgb_want.blue)
                begin
                    mismatch_count++;
                    if (mismatch_count + stray_count <= REPORT_LIMIT)
                        $display("%0t: word %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                 $realtime, words_checked, rgb_want.red, rgb_want.green,
                                 rgb_want.blue, pix_rgb.red, pix_rgb.green, pix_rgb.blue);
                end
            end
        end
    end

    // Give up if neither channel moves a word for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (pix_hsv_valid && pix_hsv_ready) || (pix_rgb_valid && pix_rgb_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no word accepted for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words first, with both sides running flat out.
        test_sector_edges();
        test_hue_wrap();
        test_channel_extremes();

        // Random pixels under four kinds of handshake pressure.
        test_random_pixels(350, 0, 0);
        test_random_pixels(350, 85, 0);
        test_random_pixels(350, 0, 85);
        test_random_pixels(350, 32, 32);

        // Anything that comes out from here on is a stray word.
        repeat (TAIL_CYCLES)
            @(posedge clk);

        $display("Checked %0d of %0d HSV words: directed sector edges, hue wrap and grey pixels,",
                 words_checked, words_sent);
        $display("then random pixels with free-running, idle-sender, stalled and mixed handshakes.");
        if (mismatch_count == 0 && stray_count == 0 && rgb_pending.size() == 0)
            $display("tb OK");
        else
        begin
            $display("%0d mismatches, %0d stray words, %0d words missing",
                     mismatch_count, stray_count, rgb_pending.size());
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/hsv2rgb_pkg.sv
rtl/hsv2rgb_sector.sv
rtl/hsv2rgb_numer.sv
rtl/hsv2rgb_recip.sv
rtl/hsv_to_rgb_pixel_top.sv
bench/tb.sv
